// ===== design/bfpa_pkg.sv =====
`timescale 1ns / 1ps
// bfpa_pkg: shared types, constants and helpers for the best-fit page allocator
// depends on nothing; used by best_fit_page_allocator_core and its testbench

package bfpa_pkg;

  localparam int MaxBlocks = 64;
  localparam int PageW     = 20;
  localparam int LenW      = PageW + 1;
  localparam int SumW      = PageW + 2;
  localparam int IdxW      = $clog2(MaxBlocks);
  localparam int CntW      = IdxW + 1;

  localparam logic [CntW-1:0] UsedMax = CntW'(MaxBlocks);
  localparam logic [LenW-1:0] FreeMax = LenW'(1) << PageW;
  localparam logic [LenW-1:0] LenMax  = {LenW{1'b1}};

  // request kinds
  localparam logic [1:0] ModeAdd   = 2'd0;
  localparam logic [1:0] ModeAlloc = 2'd1;
  localparam logic [1:0] ModeFree  = 2'd2;
  localparam logic [1:0] ModeNone  = 2'd3;

  // status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNoFit = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;
  localparam logic [1:0] StZero  = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [PageW-1:0] page_index;
    logic [LenW-1:0]  page_count;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PageW-1:0] alloc_index;
    logic [LenW-1:0]  free_total;
  } resp_t;

  typedef struct packed {
    logic [PageW-1:0] start;
    logic [LenW-1:0]  len;
  } entry_t;

  // saturating length from a grown sum
  function automatic logic [LenW-1:0] sat_len(input logic [SumW-1:0] v);
    sat_len = v[SumW-1] ? LenMax : v[LenW-1:0];
  endfunction

endpackage

// ===== design/best_fit_page_allocator_core.sv =====
`timescale 1ns / 1ps
// best_fit_page_allocator_core: best-fit page allocator with free-block coalescing
// depends on bfpa_pkg (types, constants, sat_len)

// Usage
// - request word on in_data_i (mode, page_index, page_count) with in_valid_i/in_ready_o
// - one result word per request on out_data_o with out_valid_o/out_ready_i
// - the free-block table (64 entries) sits in a single-port-read, single-port-write
//   memory; a sequencer scans it one entry per cycle, then shifts entries one per
//   cycle for inserts and removals, then writes the updated entry
// - a request runs the scan, a merge step for add/free, the shifting, a write and a
//   response step; the longest request is an exact-fit allocate that removes the
//   lowest entry
// - the block takes one request at a time: in_ready_o is high only while idle
// - a finished result waits in the output register; a new request may be accepted
//   while it waits, but its own result is held until the previous word is taken
// - after reset the table is empty and the free count is zero; no clearing pass
//   is needed because only entries below the fill count are read

module best_fit_page_allocator_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bfpa_pkg::req_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bfpa_pkg::resp_t   out_data_o
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StScan  = 6'b000010,
    StMerge = 6'b000100,
    StShift = 6'b001000,
    StWrite = 6'b010000,
    StResp  = 6'b100000
  } state_e;

  localparam int CW = bfpa_pkg::CntW;
  localparam int IW = bfpa_pkg::IdxW;
  localparam int SW = bfpa_pkg::SumW;

  state_e state_q, state_d;

  logic [CW-1:0] used_q, used_d;
  logic [bfpa_pkg::LenW-1:0] free_q, free_d;
  bfpa_pkg::req_t req_q, req_d;

  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          dir_up_q, dir_up_d;
  logic          rd_vld_q, rd_vld_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  bfpa_pkg::entry_t rd_data_q;

  logic          found_q, found_d;
  logic [CW-1:0] best_idx_q, best_idx_d;
  bfpa_pkg::entry_t best_q, best_d;

  logic          stop_q, stop_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          prev_vld_q, prev_vld_d;
  bfpa_pkg::entry_t prev_q, prev_d;
  logic          next_vld_q, next_vld_d;
  bfpa_pkg::entry_t next_q, next_d;
  logic          lo_q, lo_d;

  bfpa_pkg::entry_t cur_q, cur_d;
  logic [CW-1:0] wr_idx_q, wr_idx_d;
  logic          wr_en_q, wr_en_d;

  logic [1:0] status_q, status_d;
  logic [bfpa_pkg::PageW-1:0] alloc_q, alloc_d;

  logic out_valid_q, out_valid_d;
  bfpa_pkg::resp_t out_q, out_d;

  // memory port signals
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  bfpa_pkg::entry_t mem_wdata;

  bfpa_pkg::entry_t mem_q [bfpa_pkg::MaxBlocks];

  // helper sums
  logic [SW-1:0] prev_end, cur_end, free_sum, lo_sum, hi_sum;
  logic          hi;
  logic          is_alloc;

  // remainder start, wrapped to the page space
  function automatic logic [bfpa_pkg::PageW-1:0] best_sum_start(
    input logic [bfpa_pkg::PageW-1:0] s,
    input logic [bfpa_pkg::LenW-1:0]  n
  );
    logic [bfpa_pkg::LenW-1:0] t;
    t = {1'b0, s} + n;
    best_sum_start = t[bfpa_pkg::PageW-1:0];
  endfunction

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign is_alloc    = (req_q.mode == bfpa_pkg::ModeAlloc);

  assign prev_end = {2'b00, prev_q.start} + {1'b0, prev_q.len};
  assign lo_sum   = {1'b0, prev_q.len} + {1'b0, req_q.page_count};
  assign free_sum = {1'b0, free_q} + {1'b0, req_q.page_count};
  assign cur_end  = {2'b00, cur_q.start} + {1'b0, cur_q.len};
  assign hi_sum   = {1'b0, cur_q.len} + {1'b0, next_q.len};
  assign hi       = (req_q.mode == bfpa_pkg::ModeFree) && next_vld_q &&
                    (cur_end == {2'b00, next_q.start});

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    free_d      = free_q;
    req_d       = req_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    dir_up_d    = dir_up_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = ptr_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    stop_d      = stop_q;
    pos_d       = pos_q;
    prev_vld_d  = prev_vld_q;
    prev_d      = prev_q;
    next_vld_d  = next_vld_q;
    next_d      = next_q;
    lo_d        = lo_q;
    cur_d       = cur_q;
    wr_idx_d    = wr_idx_q;
    wr_en_d     = wr_en_q;
    status_d    = status_q;
    alloc_d     = alloc_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q[IW-1:0];
    mem_we      = 1'b0;
    mem_waddr   = wr_idx_q[IW-1:0];
    mem_wdata   = cur_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d      = in_data_i;
          status_d   = bfpa_pkg::StOk;
          alloc_d    = '0;
          ptr_d      = '0;
          found_d    = 1'b0;
          stop_d     = 1'b0;
          prev_vld_d = 1'b0;
          next_vld_d = 1'b0;
          pos_d      = used_q;
          state_d    = StScan;
          if (in_data_i.mode == bfpa_pkg::ModeNone) begin
            state_d = StResp;
          end else if (in_data_i.page_count == '0) begin
            status_d = bfpa_pkg::StZero;
            state_d  = StResp;
          end else if (in_data_i.mode == bfpa_pkg::ModeAlloc) begin
            if (in_data_i.page_count > free_q) begin
              status_d = bfpa_pkg::StNoFit;
              state_d  = StResp;
            end
          end else if (used_q >= bfpa_pkg::UsedMax) begin
            status_d = bfpa_pkg::StFull;
            state_d  = StResp;
          end
        end
      end

      StScan: begin
        // issue one read per cycle
        if (ptr_q < used_q && !stop_q) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q + CW'(1);
        end
        // look at the entry read last cycle
        if (rd_vld_q && !stop_q) begin
          if (is_alloc) begin
            if (rd_data_q.len >= req_q.page_count &&
                (!found_q || rd_data_q.len < best_q.len)) begin
              found_d    = 1'b1;
              best_idx_d = rd_idx_q;
              best_d     = rd_data_q;
            end
          end else if (rd_data_q.start > req_q.page_index) begin
            stop_d     = 1'b1;
            pos_d      = rd_idx_q;
            next_vld_d = 1'b1;
            next_d     = rd_data_q;
          end else begin
            prev_vld_d = 1'b1;
            prev_d     = rd_data_q;
          end
        end
        if (stop_q || (ptr_q >= used_q && !rd_vld_q)) begin
          if (is_alloc) begin
            if (!found_q) begin
              status_d = bfpa_pkg::StNoFit;
              state_d  = StResp;
            end else begin
              alloc_d  = best_q.start;
              free_d   = free_q - req_q.page_count;
              wr_idx_d = best_idx_q;
              state_d  = StShift;
              if (best_q.len > req_q.page_count) begin
                cur_d.start = best_sum_start(best_q.start, req_q.page_count);
                cur_d.len   = best_q.len - req_q.page_count;
                wr_en_d     = 1'b1;
                cnt_d       = '0;
              end else begin
                wr_en_d  = 1'b0;
                dir_up_d = 1'b0;
                ptr_d    = best_idx_q + CW'(1);
                cnt_d    = used_q - CW'(1) - best_idx_q;
                used_d   = used_q - CW'(1);
              end
            end
          end else begin
            free_d = (free_sum > {1'b0, bfpa_pkg::FreeMax}) ? bfpa_pkg::FreeMax
                                                              : free_sum[bfpa_pkg::LenW-1:0];
            lo_d = (req_q.mode == bfpa_pkg::ModeFree) && prev_vld_q &&
                   (prev_end == {2'b00, req_q.page_index});
            if ((req_q.mode == bfpa_pkg::ModeFree) && prev_vld_q &&
                (prev_end == {2'b00, req_q.page_index})) begin
              cur_d.start = prev_q.start;
              cur_d.len   = bfpa_pkg::sat_len(lo_sum);
            end else begin
              cur_d.start = req_q.page_index;
              cur_d.len   = req_q.page_count;
            end
            state_d = StMerge;
          end
        end
      end

      StMerge: begin
        wr_en_d = 1'b1;
        state_d = StShift;
        if (hi) begin
          cur_d.len = bfpa_pkg::sat_len(hi_sum);
        end
        priority if (lo_q && hi) begin
          // both neighbors join: drop the upper one
          wr_idx_d = pos_q - CW'(1);
          dir_up_d = 1'b0;
          ptr_d    = pos_q + CW'(1);
          cnt_d    = used_q - CW'(1) - pos_q;
          used_d   = used_q - CW'(1);
        end else if (lo_q) begin
          wr_idx_d = pos_q - CW'(1);
          cnt_d    = '0;
        end else if (hi) begin
          wr_idx_d = pos_q;
          cnt_d    = '0;
        end else begin
          // plain insert: open a slot at pos
          wr_idx_d = pos_q;
          dir_up_d = 1'b1;
          ptr_d    = used_q - CW'(1);
          cnt_d    = used_q - pos_q;
          used_d   = used_q + CW'(1);
        end
      end

      StShift: begin
        // pipelined move: read one entry, write it one slot over next cycle
        if (cnt_q != '0) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q - CW'(1);
          ptr_d    = dir_up_q ? ptr_q - CW'(1) : ptr_q + CW'(1);
        end
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data_q;
          mem_waddr = dir_up_q ? IW'(rd_idx_q + CW'(1)) : IW'(rd_idx_q - CW'(1));
        end
        if (cnt_q == '0) begin
          state_d = wr_en_q ? StWrite : StResp;
        end
      end

      StWrite: begin
        mem_we  = 1'b1;
        state_d = StResp;
      end

      StResp: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.status      = status_q;
          out_d.alloc_index = alloc_q;
          out_d.free_total  = free_q;
          state_d           = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      free_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      free_q      <= free_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    ptr_q      <= ptr_d;
    cnt_q      <= cnt_d;
    dir_up_q   <= dir_up_d;
    rd_idx_q   <= rd_idx_d;
    found_q    <= found_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    stop_q     <= stop_d;
    pos_q      <= pos_d;
    prev_vld_q <= prev_vld_d;
    prev_q     <= prev_d;
    next_vld_q <= next_vld_d;
    next_q     <= next_d;
    lo_q       <= lo_d;
    cur_q      <= cur_d;
    wr_idx_q   <= wr_idx_d;
    wr_en_q    <= wr_en_d;
    status_q   <= status_d;
    alloc_q    <= alloc_d;
    out_q      <= out_d;
  end

`ifndef SYNTHESIS
  // table fill never passes its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= bfpa_pkg::UsedMax)
    else $error("table fill count beyond depth");

  // the reported free total stays saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.free_total <= bfpa_pkg::FreeMax)
    else $error("free total above page space");

  // an accepted request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready held high after accept");
`endif

endmodule

// ===== dv/best_fit_page_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// best_fit_page_allocator_core_tb: self-checking bench for the best-fit page allocator
// depends on bfpa_pkg and best_fit_page_allocator_core; tracks the free table itself

module best_fit_page_allocator_core_tb;

  localparam int IdleCycleLimit = 20000;
  localparam int DrainCycles    = 200;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  bfpa_pkg::req_t  in_data;
  logic            out_valid;
  logic            out_ready;
  bfpa_pkg::resp_t out_data;

  // free table mirror
  logic [bfpa_pkg::PageW-1:0] tbl_start [bfpa_pkg::MaxBlocks];
  logic [bfpa_pkg::LenW-1:0]  tbl_len   [bfpa_pkg::MaxBlocks];
  int                         tbl_used;
  logic [bfpa_pkg::LenW-1:0]  pages_free;

  bfpa_pkg::resp_t expected_words[$];
  int    fail_count;
  int    idle_cycles;
  bit    hold_off;

  best_fit_page_allocator_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // remove one table entry, shifting the rest down
  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < tbl_used; i++) begin
      tbl_start[i] = tbl_start[i + 1];
      tbl_len[i]   = tbl_len[i + 1];
    end
    tbl_used--;
  endfunction

  // update the table mirror for one request and return the expected word
  function automatic bfpa_pkg::resp_t allocator_step(input bfpa_pkg::req_t r);
    bfpa_pkg::resp_t            w;
    int                         pos;
    int                         best;
    bit                         found;
    logic [bfpa_pkg::LenW-1:0]  gap;
    logic [bfpa_pkg::SumW-1:0]  total;
    logic [bfpa_pkg::SumW-1:0]  sum;
    w = '0;
    if (r.mode == bfpa_pkg::ModeNone) begin
      // unused kind: no change
    end else if (r.page_count == 0) begin
      w.status = bfpa_pkg::StZero;
    end else if (r.mode == bfpa_pkg::ModeAlloc) begin
      found = 1'b0;
      best  = 0;
      gap   = '0;
      if (r.page_count > pages_free) begin
        w.status = bfpa_pkg::StNoFit;
      end else begin
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_len[i] >= r.page_count &&
              (!found || tbl_len[i] - r.page_count < gap)) begin
            found = 1'b1;
            best  = i;
            gap   = tbl_len[i] - r.page_count;
          end
        end
        if (!found) begin
          w.status = bfpa_pkg::StNoFit;
        end else begin
          w.alloc_index = tbl_start[best];
          if (tbl_len[best] > r.page_count) begin
            tbl_start[best] = tbl_start[best] + r.page_count[bfpa_pkg::PageW-1:0];
            tbl_len[best]   = tbl_len[best] - r.page_count;
          end else begin
            drop_entry(best);
          end
          pages_free = pages_free - r.page_count;
        end
      end
    end else if (tbl_used >= bfpa_pkg::MaxBlocks) begin
      w.status = bfpa_pkg::StFull;
    end else begin
      pos = 0;
      while (pos < tbl_used && tbl_start[pos] <= r.page_index) pos++;
      for (int i = tbl_used; i > pos; i--) begin
        tbl_start[i] = tbl_start[i - 1];
        tbl_len[i]   = tbl_len[i - 1];
      end
      tbl_start[pos] = r.page_index;
      tbl_len[pos]   = r.page_count;
      tbl_used++;
      total = bfpa_pkg::SumW'(pages_free) + bfpa_pkg::SumW'(r.page_count);
      pages_free = (total > bfpa_pkg::SumW'(bfpa_pkg::FreeMax)) ? bfpa_pkg::FreeMax
                                                                 : total[bfpa_pkg::LenW-1:0];
      // coalesce with neighbors on free
      if (r.mode == bfpa_pkg::ModeFree) begin
        if (pos > 0 && bfpa_pkg::SumW'(tbl_start[pos - 1]) +
            bfpa_pkg::SumW'(tbl_len[pos - 1]) == bfpa_pkg::SumW'(tbl_start[pos])) begin
          sum = bfpa_pkg::SumW'(tbl_len[pos - 1]) + bfpa_pkg::SumW'(tbl_len[pos]);
          tbl_len[pos - 1] = sum > bfpa_pkg::SumW'(bfpa_pkg::LenMax) ? bfpa_pkg::LenMax
                                                                    : sum[bfpa_pkg::LenW-1:0];
          drop_entry(pos);
          pos--;
        end
        if (pos + 1 < tbl_used && bfpa_pkg::SumW'(tbl_start[pos]) +
            bfpa_pkg::SumW'(tbl_len[pos]) == bfpa_pkg::SumW'(tbl_start[pos + 1])) begin
          sum = bfpa_pkg::SumW'(tbl_len[pos]) + bfpa_pkg::SumW'(tbl_len[pos + 1]);
          tbl_len[pos] = sum > bfpa_pkg::SumW'(bfpa_pkg::LenMax) ? bfpa_pkg::LenMax
                                                                : sum[bfpa_pkg::LenW-1:0];
          drop_entry(pos + 1);
        end
      end
    end
    w.free_total = pages_free;
    return w;
  endfunction

  // send one request word after a random gap
  task automatic send_word(input logic [1:0] mode,
                           input logic [bfpa_pkg::PageW-1:0] idx,
                           input logic [bfpa_pkg::LenW-1:0] cnt);
    bfpa_pkg::req_t r;
    int             gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.mode       = mode;
    r.page_index = idx;
    r.page_count = cnt;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(allocator_step(r));
  endtask

  // random count, mostly small
  function automatic logic [bfpa_pkg::LenW-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return bfpa_pkg::LenW'($urandom_range(0, bfpa_pkg::FreeMax));
      1:       return bfpa_pkg::LenW'($urandom) |
                      (bfpa_pkg::LenW'(1) << $urandom_range(0, bfpa_pkg::LenW - 1));
      default: return bfpa_pkg::LenW'($urandom_range(1, 64));
    endcase
  endfunction

  // edge values, every kind and each special case
  task automatic test_directed();
    send_word(bfpa_pkg::ModeAlloc, '0, 21'd1);        // alloc from empty table
    send_word(bfpa_pkg::ModeAdd, '0, '0);             // zero count
    send_word(bfpa_pkg::ModeNone, '1, '1);            // unused kind
    send_word(bfpa_pkg::ModeAdd, 20'd100, 21'd50);
    send_word(bfpa_pkg::ModeAdd, 20'd100, 21'd10);    // equal start
    send_word(bfpa_pkg::ModeAlloc, '0, 21'd10);       // exact fit removes entry
    send_word(bfpa_pkg::ModeAlloc, '0, 21'd20);       // remainder stays
    send_word(bfpa_pkg::ModeFree, 20'd100, 21'd20);   // merge with higher neighbor
    send_word(bfpa_pkg::ModeFree, 20'd90, 21'd10);    // merge with higher neighbor, lower absent
    send_word(bfpa_pkg::ModeFree, 20'd150, 21'd5);    // merge with lower neighbor
    send_word(bfpa_pkg::ModeFree, 20'd200, 21'd5);
    send_word(bfpa_pkg::ModeFree, 20'd155, 21'd45);   // merge both sides
    send_word(bfpa_pkg::ModeAlloc, '0, 21'd200);      // no fit
    send_word(bfpa_pkg::ModeAdd, '1, bfpa_pkg::FreeMax);  // free total saturates
    send_word(bfpa_pkg::ModeFree, '1, '1);            // maximum count, inserted without a merge
    send_word(bfpa_pkg::ModeAlloc, '0, 21'd3);        // best fit picks the smallest fitting block
    send_word(bfpa_pkg::ModeAlloc, '0, bfpa_pkg::FreeMax);  // count above free total: no fit
    send_word(bfpa_pkg::ModeAlloc, '0, '1);           // more than free
  endtask

  // fill the table to overflow, then allocate small pieces from it
  task automatic test_table_full();
    for (int i = 0; i < bfpa_pkg::MaxBlocks + 3; i++)
      send_word($urandom_range(0, 1) ? bfpa_pkg::ModeAdd : bfpa_pkg::ModeFree,
                bfpa_pkg::PageW'(300000 + i * 7), 21'd3);
    for (int i = 0; i < 40; i++)
      send_word(bfpa_pkg::ModeAlloc, '0, bfpa_pkg::LenW'($urandom_range(1, 4)));
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_word(bfpa_pkg::ModeFree, bfpa_pkg::PageW'($urandom), 21'd2);
    join
  endtask

  // mostly well-formed alloc/free traffic on a small page range
  task automatic test_random(input int n);
    logic [1:0]                 m;
    logic [bfpa_pkg::PageW-1:0] idx;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0:          m = bfpa_pkg::ModeNone;
        1, 2, 3:    m = bfpa_pkg::ModeAdd;
        4,5,6,7,8,9,10,11: m = bfpa_pkg::ModeAlloc;
        default:    m = bfpa_pkg::ModeFree;
      endcase
      idx = ($urandom_range(0, 9) == 0) ? bfpa_pkg::PageW'($urandom)
                                         : bfpa_pkg::PageW'($urandom_range(0, 4095));
      send_word(m, idx, ($urandom_range(0, 29) == 0) ? '0 : pick_count());
    end
  endtask

  // result checker
  always @(posedge clk) begin
    bfpa_pkg::resp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        fail_count++;
      end else begin
        e = expected_words.pop_front();
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          fail_count++;
        end
        if (out_data.alloc_index !== e.alloc_index) begin
          $error("alloc_index expected %0d actual %0d", e.alloc_index, out_data.alloc_index);
          fail_count++;
        end
        if (out_data.free_total !== e.free_total) begin
          $error("free_total expected %0d actual %0d", e.free_total, out_data.free_total);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0 || hold_off) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // watchdog on cycles with no word accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleCycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_valid    = 1'b0;
    in_data     = '0;
    rst_n       = 1'b0;
    fail_count  = 0;
    idle_cycles = 0;
    hold_off    = 1'b0;
    tbl_used    = 0;
    pages_free  = '0;
    for (int i = 0; i < bfpa_pkg::MaxBlocks; i++) begin
      tbl_start[i] = '0;
      tbl_len[i]   = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random(1520);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
